// ===== design/uspr_pkg.sv =====
// ----------------------------------------------------------------------------
// uspr_pkg
// Shared types, constants and checksum helpers of the scatter replicator.
// ----------------------------------------------------------------------------
package uspr_pkg;

    // stream widths, fields packed from bit 0 up; tdata padded to whole bytes
    localparam int IN_TDATA_W  = 224;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 1;

    localparam int ENTRY_W = 48;

    localparam logic [15:0] UDP_REQ_LEN = 16'd15;
    // "SCATTER", first byte most significant
    localparam logic [55:0] REQ_WORD    = 56'h53434154544552;

    // kind of input transfer
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_FRAME       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST
    } t_state;

    // one's complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // incremental checksum update of one 16-bit word
    function automatic logic [15:0] csum_upd16(input logic [15:0] csum,
                                               input logic [15:0] oldv,
                                               input logic [15:0] newv);
        logic [15:0] s;
        s = ~csum;
        s = oc_add(s, ~oldv);
        s = oc_add(s, newv);
        return ~s;
    endfunction

endpackage

// ===== design/uspr_ram.sv =====
// ----------------------------------------------------------------------------
// uspr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module uspr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/udp_scatter_packet_replicator_unit.sv =====
// ----------------------------------------------------------------------------
// udp_scatter_packet_replicator_unit
// Rewrites self-addressed scatter requests into one clone per worker table
// entry followed by the original frame; other frames pass through.
// ----------------------------------------------------------------------------
// A pass-through result is on m_axis in the cycle after its input transfer; the first
// clone of a scatter request goes through the table read register, then the output register.
// A request with n workers holds off new input through accept, n clones and original;
// the walk reads one table entry per cycle while m_axis_tready allows.
// Reset: synchronous, active low; clears the state machine, the output valid bit,
// app_port and one valid bit per table entry at once, no sweep.
module udp_scatter_packet_replicator_unit
    import uspr_pkg::*;
#(
    parameter int MAX_WORKERS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: app_port
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // worker_index, worker address, worker port, ip_dest, ip_checksum, udp_source,
    // udp_dest, udp_length, udp_checksum, payload_head, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation, frame_ok
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_ip_dest, out_udp_dest, out_ip_checksum, out_udp_checksum
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // is_clone
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    // input fields
    logic        in_op;
    logic        in_frame_ok;
    logic [3:0]  in_widx;
    logic [31:0] in_wip;
    logic [15:0] in_wport;
    logic [31:0] in_ip;
    logic [15:0] in_ipc;
    logic [15:0] in_sport;
    logic [15:0] in_dport;
    logic [15:0] in_ulen;
    logic [15:0] in_udpc;
    logic [55:0] in_head;

    assign in_op       = s_axis_tuser[0];
    assign in_frame_ok = s_axis_tuser[1];
    assign in_widx     = s_axis_tdata[3:0];
    assign in_wip      = s_axis_tdata[35:4];
    assign in_wport    = s_axis_tdata[51:36];
    assign in_ip       = s_axis_tdata[83:52];
    assign in_ipc      = s_axis_tdata[99:84];
    assign in_sport    = s_axis_tdata[115:100];
    assign in_dport    = s_axis_tdata[131:116];
    assign in_ulen     = s_axis_tdata[147:132];
    assign in_udpc     = s_axis_tdata[163:148];
    assign in_head     = s_axis_tdata[219:164];

    t_state r_state, n_state;
    logic [15:0] r_app_port;
    logic [MAX_WORKERS-1:0] r_valid;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_rd_ok;

    // running header of the request
    logic [31:0] r_ip, n_ip;
    logic [15:0] r_port, n_port;
    logic [15:0] r_ipc, n_ipc;
    logic [15:0] r_udpc, n_udpc;

    // output register
    logic        r_out_valid, n_out_valid;
    logic        r_out_clone, n_out_clone;
    logic        r_out_last, n_out_last;
    logic [31:0] r_out_ip, n_out_ip;
    logic [15:0] r_out_port, n_out_port;
    logic [15:0] r_out_ipc, n_out_ipc;
    logic [15:0] r_out_udpc, n_out_udpc;

    logic               out_free;
    logic               in_xfer;
    logic               is_request;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [31:0] w_ip;
    logic [15:0] w_port;
    logic        entry_end;
    logic [15:0] ipc_hi, ipc_lo;
    logic [15:0] udpc_hi, udpc_lo, udpc_port;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign is_request = in_frame_ok && (in_sport == in_dport) && (in_sport == r_app_port)
                     && (in_ulen == UDP_REQ_LEN) && (in_head == REQ_WORD);

    // indexes past the table are dropped
    assign mem_we    = in_xfer && (in_op == OP_TABLE_WRITE) && (32'(in_widx) < MAX_WORKERS);
    assign mem_waddr = AW'(in_widx);

    uspr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WORKERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({in_wip, in_wport}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_ip   = mem_rdata[47:16];
    assign w_port = mem_rdata[15:0];
    // a never-written entry (valid bit clear), a zero address or a zero port ends the walk
    assign entry_end = !r_rd_ok || (w_ip == 32'd0) || (w_port == 16'd0);

    assign ipc_hi    = csum_upd16(r_ipc, r_ip[31:16], w_ip[31:16]);
    assign ipc_lo    = csum_upd16(ipc_hi, r_ip[15:0], w_ip[15:0]);
    assign udpc_hi   = csum_upd16(r_udpc, r_ip[31:16], w_ip[31:16]);
    assign udpc_lo   = csum_upd16(udpc_hi, r_ip[15:0], w_ip[15:0]);
    assign udpc_port = csum_upd16(udpc_lo, r_port, w_port);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ip        = r_ip;
        n_port      = r_port;
        n_ipc       = r_ipc;
        n_udpc      = r_udpc;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_clone = r_out_clone;
        n_out_last  = r_out_last;
        n_out_ip    = r_out_ip;
        n_out_port  = r_out_port;
        n_out_ipc   = r_out_ipc;
        n_out_udpc  = r_out_udpc;
        mem_re      = 1'b0;
        mem_raddr   = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (in_op == OP_FRAME)) begin
                    n_ip   = in_ip;
                    n_port = in_dport;
                    n_ipc  = in_ipc;
                    n_udpc = in_udpc;
                    if (is_request) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_idx     = '0;
                        n_state   = ST_WALK;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_clone = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_ip    = in_ip;
                        n_out_port  = in_dport;
                        n_out_ipc   = in_ipc;
                        n_out_udpc  = in_udpc;
                    end
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (entry_end) begin
                        n_out_clone = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_ip    = r_ip;
                        n_out_port  = r_port;
                        n_out_ipc   = r_ipc;
                        n_out_udpc  = r_udpc;
                        n_state     = ST_IDLE;
                    end else begin
                        n_ip        = w_ip;
                        n_port      = w_port;
                        n_ipc       = ipc_lo;
                        n_udpc      = udpc_port;
                        n_out_clone = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_ip    = w_ip;
                        n_out_port  = w_port;
                        n_out_ipc   = ipc_lo;
                        n_out_udpc  = udpc_port;
                        if (r_idx == AW'(MAX_WORKERS - 1)) begin
                            n_state = ST_LAST;
                        end else begin
                            // fetch the next entry while this clone goes out
                            mem_re    = 1'b1;
                            mem_raddr = r_idx + AW'(1);
                            n_idx     = r_idx + AW'(1);
                        end
                    end
                end
            end
            ST_LAST: begin
                // table full: original with the final rewrite
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_clone = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_ip    = r_ip;
                    n_out_port  = r_port;
                    n_out_ipc   = r_ipc;
                    n_out_udpc  = r_udpc;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_app_port  <= 16'd0;
            r_valid     <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (i_cfg_we) begin
                r_app_port <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_ok <= r_valid[mem_raddr];
        end
        r_ip       <= n_ip;
        r_port     <= n_port;
        r_ipc      <= n_ipc;
        r_udpc     <= n_udpc;
        r_out_clone <= n_out_clone;
        r_out_last <= n_out_last;
        r_out_ip   <= n_out_ip;
        r_out_port <= n_out_port;
        r_out_ipc  <= n_out_ipc;
        r_out_udpc <= n_out_udpc;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_udpc, r_out_ipc, r_out_port, r_out_ip};
    assign m_axis_tuser  = r_out_clone;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== design/uspr_checker.sv =====
// ----------------------------------------------------------------------------
// uspr_checker
// Port-level assertions on the scatter replicator, bound to the top level.
// ----------------------------------------------------------------------------
module uspr_checker
    import uspr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [15:0]            i_cfg_wdata,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // clones never close a frame, the original always does
    a_last_marks_original: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tlast))
        else $error("tlast does not match clone flag");

    // no new input while a request is still being replicated
    a_no_accept_mid_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !s_axis_tready)
        else $error("input accepted during replication");

    // output register empties on reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind udp_scatter_packet_replicator_unit uspr_checker u_uspr_checker (.*);
